[hw/rtl/circular_list_engine_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the circular list engine
// Concurrent checks on clk_i, switched off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_LIST_ENGINE_CORE_ASSERT_SVH
`define CIRCULAR_LIST_ENGINE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CLE_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("circular list engine: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CLE_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("circular list engine: next-cycle check failed");

`endif

[hw/rtl/cle_pkg.sv]
// ----------------------------------------------------------------------------
// Circular list engine package
// Shared defaults, command and status codes, and the free pool control type.
// ----------------------------------------------------------------------------
`default_nettype none

package cle_pkg;

  localparam int CLE_CAPACITY   = 32;
  localparam int CLE_DATA_WIDTH = 32;

  typedef enum logic [1:0] {
    CLE_CMD_APPEND  = 2'd0,
    CLE_CMD_PREPEND = 2'd1,
    CLE_CMD_DELETE  = 2'd2,
    CLE_CMD_READ    = 2'd3
  } cle_cmd_e;

  typedef enum logic [1:0] {
    CLE_ST_OK    = 2'd0,
    CLE_ST_EMPTY = 2'd1,
    CLE_ST_RANGE = 2'd2,
    CLE_ST_FULL  = 2'd3
  } cle_status_e;

  typedef struct packed {
    logic pop;
    logic push;
  } cle_pool_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/cle_free_pool.sv]
// ----------------------------------------------------------------------------
// Free node pool
// Stack of unused node indices; entries never pushed read as their own index.
// ----------------------------------------------------------------------------
`default_nettype none

module cle_free_pool
  import cle_pkg::*;
#(
  parameter int CAPACITY = CLE_CAPACITY,
  parameter int IW       = $clog2(CAPACITY),
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire cle_pool_ctl_t ctl_i,
  input  wire logic [IW-1:0] push_idx_i,
  output logic      [IW-1:0] pop_idx_o,
  output logic               empty_o,
  output logic      [CW-1:0] free_cnt_o
);

  logic [CW-1:0]       top_q, top_d;
  logic [CAPACITY-1:0] vld_q;
  logic [IW-1:0]       stack_mem [CAPACITY];
  logic [IW-1:0]       rd_q;
  logic [IW-1:0]       pop_addr;
  logic [IW-1:0]       push_addr;
  logic                do_pop;
  logic                do_push;

  assign pop_addr  = IW'(top_q - CW'(1));
  assign push_addr = top_q[IW-1:0];
  assign empty_o   = (top_q == '0);
  assign do_pop    = ctl_i.pop && !empty_o;
  assign do_push   = ctl_i.push && (top_q != CW'(CAPACITY));

  always_comb begin
    top_d = top_q;
    if (do_pop) begin
      top_d = top_q - CW'(1);
    end else if (do_push) begin
      top_d = top_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= CW'(CAPACITY);
      vld_q <= '0;
    end else begin
      top_q <= top_d;
      if (do_push) begin
        vld_q[push_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      stack_mem[push_addr] <= push_idx_i;
    end
    if (do_pop) begin
      rd_q <= vld_q[pop_addr] ? stack_mem[pop_addr] : pop_addr;
    end
  end

  assign pop_idx_o  = rd_q;
  assign free_cnt_o = top_q;

endmodule

`default_nettype wire

[hw/rtl/circular_list_engine_core.sv]
// ----------------------------------------------------------------------------
// Circular list engine
// Doubly linked circular list in a node pool, driven by stream commands.
// ----------------------------------------------------------------------------
// Commands arrive on the slave stream with the command code in tuser and are
// taken one at a time; tready is high only while the engine is idle. Append
// and prepend pass through ST_INS_A, ST_INS_B and ST_EMIT before the result
// register is loaded, and skip ST_INS_B when the list is empty. Delete at
// position p follows p - 1 links from the head and read out one link per
// element after the first, because each step uses the single read port of
// the node memories. A command refused with an error status goes straight
// to ST_EMIT, and a result that waits on the master stream holds the engine
// for as long as it waits. Read out returns each element as its own transfer,
// with tlast on the final one; every other command returns exactly one
// transfer with tlast set. The status code travels in tuser on the master
// stream. Only the low DATA_WIDTH bits of a value are kept.
`default_nettype none

`include "circular_list_engine_core_assert.svh"

module circular_list_engine_core
  import cle_pkg::*;
#(
  parameter int CAPACITY   = CLE_CAPACITY,
  parameter int DATA_WIDTH = CLE_DATA_WIDTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [31:0] value, [37:32] position, [39:38] zero
  input  wire logic [39:0] s_axis_tdata,
  // [1:0] cmd
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [31:0] item_value, [37:32] element_count, [39:38] zero
  output logic [39:0]      m_axis_tdata,
  // [1:0] status
  output logic [1:0]       m_axis_tuser,
  output logic             m_axis_tlast
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > 6) ? CW : 6;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_INS_A    = 6'b000010,
    ST_INS_B    = 6'b000100,
    ST_DEL_WALK = 6'b001000,
    ST_RD_WALK  = 6'b010000,
    ST_EMIT     = 6'b100000
  } state_e;

  state_e          state_q, state_d;
  logic [IW-1:0]   head_q, head_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   k_q, k_d;
  logic [IW-1:0]   cur_q, cur_d;
  logic            first_q, first_d;
  cle_status_e     st_q, st_d;
  logic [31:0]     value_q, value_d;

  logic [DATA_WIDTH-1:0] node_mem [CAPACITY];
  logic [IW-1:0]         next_mem [CAPACITY];
  logic [IW-1:0]         prev_mem [CAPACITY];
  logic [DATA_WIDTH-1:0] value_rd_q;
  logic [IW-1:0]         next_rd_q;
  logic [IW-1:0]         prev_rd_q;

  logic                  rd_en;
  logic [IW-1:0]         rd_addr;
  logic                  val_we;
  logic [IW-1:0]         val_waddr;
  logic [DATA_WIDTH-1:0] val_wdata;
  logic                  nxt_we;
  logic [IW-1:0]         nxt_waddr;
  logic [IW-1:0]         nxt_wdata;
  logic                  prv_we;
  logic [IW-1:0]         prv_waddr;
  logic [IW-1:0]         prv_wdata;

  cle_pool_ctl_t pool_ctl;
  logic [IW-1:0] pool_idx;
  logic          pool_empty;
  logic [CW-1:0] pool_free_cnt;

  logic          out_valid_q;
  logic [31:0]   out_item_q, out_item_d;
  cle_status_e   out_st_q, out_st_d;
  logic [5:0]    out_cnt_q;
  logic          out_last_q, out_last_d;
  logic          out_load;
  logic          out_free;

  cle_cmd_e      in_cmd;
  logic [31:0]   in_value;
  logic [5:0]    in_pos;
  logic [PW-1:0] pos_ext;
  logic [PW-1:0] cnt_ext;
  logic          accept;
  logic          list_empty;

  logic [DATA_WIDTH+31:0] val_ext;
  logic [DATA_WIDTH+31:0] item_ext;
  logic [CW:0]            occupancy;
  logic                   full_insert;

  assign in_cmd     = cle_cmd_e'(s_axis_tuser);
  assign in_value   = s_axis_tdata[31:0];
  assign in_pos     = s_axis_tdata[37:32];
  assign pos_ext    = PW'(in_pos);
  assign cnt_ext    = PW'(count_q);
  assign accept     = s_axis_tvalid && s_axis_tready;
  assign list_empty = (count_q == '0);
  assign out_free   = !out_valid_q || m_axis_tready;

  assign val_ext   = {{DATA_WIDTH{1'b0}}, value_q};
  assign val_wdata = val_ext[DATA_WIDTH-1:0];
  assign item_ext  = {32'b0, value_rd_q};

  cle_free_pool #(
    .CAPACITY (CAPACITY),
    .IW       (IW),
    .CW       (CW)
  ) u_pool (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (pool_ctl),
    .push_idx_i (cur_q),
    .pop_idx_o  (pool_idx),
    .empty_o    (pool_empty),
    .free_cnt_o (pool_free_cnt)
  );

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    count_d    = count_q;
    k_d        = k_q;
    cur_d      = cur_q;
    first_d    = first_q;
    st_d       = st_q;
    value_d    = value_q;
    rd_en      = 1'b0;
    rd_addr    = head_q;
    val_we     = 1'b0;
    val_waddr  = pool_idx;
    nxt_we     = 1'b0;
    nxt_waddr  = pool_idx;
    nxt_wdata  = pool_idx;
    prv_we     = 1'b0;
    prv_waddr  = pool_idx;
    prv_wdata  = pool_idx;
    pool_ctl   = '0;
    out_load   = 1'b0;
    out_item_d = '0;
    out_st_d   = st_q;
    out_last_d = 1'b1;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          value_d = in_value;
          st_d    = CLE_ST_OK;
          case (in_cmd)
            CLE_CMD_APPEND, CLE_CMD_PREPEND: begin
              first_d = (in_cmd == CLE_CMD_PREPEND);
              if (pool_empty) begin
                st_d    = CLE_ST_FULL;
                state_d = ST_EMIT;
              end else begin
                pool_ctl.pop = 1'b1;
                rd_en        = 1'b1;
                state_d      = ST_INS_A;
              end
            end
            CLE_CMD_DELETE: begin
              if (list_empty) begin
                st_d    = CLE_ST_EMPTY;
                state_d = ST_EMIT;
              end else if ((in_pos == '0) || (pos_ext > cnt_ext)) begin
                st_d    = CLE_ST_RANGE;
                state_d = ST_EMIT;
              end else begin
                rd_en   = 1'b1;
                cur_d   = head_q;
                k_d     = CW'(pos_ext - PW'(1));
                first_d = (in_pos == 6'd1);
                state_d = ST_DEL_WALK;
              end
            end
            CLE_CMD_READ: begin
              if (list_empty) begin
                st_d    = CLE_ST_EMPTY;
                state_d = ST_EMIT;
              end else begin
                rd_en   = 1'b1;
                k_d     = count_q - CW'(1);
                state_d = ST_RD_WALK;
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_INS_A: begin
        val_we    = 1'b1;
        nxt_we    = 1'b1;
        nxt_wdata = list_empty ? pool_idx : head_q;
        prv_we    = 1'b1;
        prv_wdata = list_empty ? pool_idx : prev_rd_q;
        count_d   = count_q + CW'(1);
        if (list_empty) begin
          head_d  = pool_idx;
          state_d = ST_EMIT;
        end else begin
          state_d = ST_INS_B;
        end
      end
      ST_INS_B: begin
        nxt_we    = 1'b1;
        nxt_waddr = prev_rd_q;
        prv_we    = 1'b1;
        prv_waddr = head_q;
        if (first_q) begin
          head_d = pool_idx;
        end
        state_d = ST_EMIT;
      end
      ST_DEL_WALK: begin
        if (k_q != '0) begin
          cur_d   = next_rd_q;
          rd_en   = 1'b1;
          rd_addr = next_rd_q;
          k_d     = k_q - CW'(1);
        end else begin
          if (count_q != CW'(1)) begin
            nxt_we    = 1'b1;
            nxt_waddr = prev_rd_q;
            nxt_wdata = next_rd_q;
            prv_we    = 1'b1;
            prv_waddr = next_rd_q;
            prv_wdata = prev_rd_q;
            if (first_q) begin
              head_d = next_rd_q;
            end
          end else begin
            head_d = '0;
          end
          count_d       = count_q - CW'(1);
          pool_ctl.push = 1'b1;
          state_d       = ST_EMIT;
        end
      end
      ST_RD_WALK: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_item_d = item_ext[31:0];
          out_st_d   = CLE_ST_OK;
          out_last_d = (k_q == '0);
          if (k_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = next_rd_q;
            k_d     = k_q - CW'(1);
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      k_q         <= '0;
      cur_q       <= '0;
      first_q     <= 1'b0;
      st_q        <= CLE_ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      k_q     <= k_d;
      cur_q   <= cur_d;
      first_q <= first_d;
      st_q    <= st_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    if (out_load) begin
      out_item_q <= out_item_d;
      out_st_q   <= out_st_d;
      out_cnt_q  <= 6'(count_q);
      out_last_q <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      node_mem[val_waddr] <= val_wdata;
    end
    if (nxt_we) begin
      next_mem[nxt_waddr] <= nxt_wdata;
    end
    if (prv_we) begin
      prev_mem[prv_waddr] <= prv_wdata;
    end
    if (rd_en) begin
      value_rd_q <= node_mem[rd_addr];
      next_rd_q  <= next_mem[rd_addr];
      prev_rd_q  <= prev_mem[rd_addr];
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_cnt_q, out_item_q};
  assign m_axis_tuser  = out_st_q;
  assign m_axis_tlast  = out_last_q;

  assign occupancy   = (CW + 1)'(count_q) + (CW + 1)'(pool_free_cnt);
  assign full_insert = accept && (in_cmd != CLE_CMD_DELETE) && (in_cmd != CLE_CMD_READ)
                       && pool_empty;

  `CLE_ASSERT_IMP(a_nodes_conserved, state_q == ST_IDLE, occupancy == (CW + 1)'(CAPACITY))
  `CLE_ASSERT_IMP(a_error_is_last, m_axis_tvalid && (m_axis_tuser != CLE_ST_OK), m_axis_tlast)
  `CLE_ASSERT_NXT(a_full_reports, full_insert, state_q == ST_EMIT && st_q == CLE_ST_FULL)

endmodule

`default_nettype wire
